FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/asc_pkg.sv
package asc_pkg;

    // Fixed widths of the item fields
    localparam int IN_BITS            = 16;
    localparam int SUM_BITS           = 18;
    localparam int VALUE_BITS_DEFAULT = 16;

    typedef struct packed {
        logic [IN_BITS-1:0] value_a;
        logic [IN_BITS-1:0] value_b;
    } in_item_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum_a;
        logic [SUM_BITS-1:0] sum_b;
        logic                a_is_abundant;
        logic                pair_is_amicable;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic sel_second;
        logic init_num;
        logic div_start;
        logic accum;
        logic store_sum;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sq_gt_n;
        logic div_done;
    } status_t;

endpackage

FILE: src/aliquot_sum_classifier.sv
// Search: each value is tested with the bit-serial trial divider, once per candidate
//   divisor from 2 up to the square root of the value.
// Throughput: one item at a time; the next item is taken once the result is registered,
//   while that result may still wait in the output register.
// Reset: rst_n asynchronous, active low; clears control state only, no clearing pass.
module aliquot_sum_classifier #(
    parameter int VALUE_BITS = asc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  asc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output asc_pkg::out_item_t result
);

    asc_pkg::cmd_t    cmd;
    asc_pkg::status_t status;

    asc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    asc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .item   (item),
        .result (result)
    );

endmodule

FILE: src/asc_div.sv
module asc_div #(
    parameter int W = asc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]       trial;
    logic             fits;
    logic [W-1:0]     diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial[W-1:0] - dsr_reg;

    // Control: count W steps, pulse done after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/asc_datapath.sv
module asc_datapath #(
    parameter int VALUE_BITS = asc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  asc_pkg::cmd_t       cmd,
    output asc_pkg::status_t    status,
    input  asc_pkg::in_item_t   item,
    output asc_pkg::out_item_t  result
);

    // Sums of numbers below 2^VALUE_BITS stay below 2^(VALUE_BITS+3)
    localparam int ACC_W = (VALUE_BITS + 3 > asc_pkg::SUM_BITS) ?
                           VALUE_BITS + 3 : asc_pkg::SUM_BITS;
    localparam int SQ_W  = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0] a_reg;
    logic [VALUE_BITS-1:0] b_reg;
    logic [VALUE_BITS-1:0] d_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      sum_first_reg;
    logic [ACC_W-1:0]      sum_second_reg;
    asc_pkg::out_item_t    result_reg;

    logic [VALUE_BITS-1:0] n;
    logic                  div_done;
    logic [VALUE_BITS-1:0] quo;
    logic [VALUE_BITS-1:0] rem;
    logic [ACC_W-1:0]      cofactor;
    logic [SQ_W-1:0]       sq_next;

    assign n = cmd.sel_second ? b_reg : a_reg;

    // Trial divider: n / d, one quotient bit per cycle
    asc_div #(
        .W (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // Cofactor counts once when it equals the divisor
    assign cofactor = (quo != d_reg) ? ACC_W'(quo) : ACC_W'(0);

    // (d+1)^2 = d^2 + 2d + 1
    assign sq_next = sq_reg + SQ_W'({d_reg, 1'b1});

    assign status.sq_gt_n  = (sq_reg > SQ_W'(n));
    assign status.div_done = div_done;

    // Hold operands, walk divisors, accumulate and store sums, register the result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg <= VALUE_BITS'(item.value_a);
            b_reg <= VALUE_BITS'(item.value_b);
        end
        if (cmd.init_num)
        begin
            // divisor 1 is counted up front; 0 and 1 have sum 0
            acc_reg <= (n < VALUE_BITS'(2)) ? ACC_W'(0) : ACC_W'(1);
            d_reg   <= VALUE_BITS'(2);
            sq_reg  <= SQ_W'(4);
        end
        else if (cmd.accum)
        begin
            if (rem == '0)
            begin
                acc_reg <= acc_reg + ACC_W'(d_reg) + cofactor;
            end
            d_reg  <= d_reg + VALUE_BITS'(1);
            sq_reg <= sq_next;
        end
        if (cmd.store_sum)
        begin
            if (cmd.sel_second)
            begin
                sum_second_reg <= acc_reg;
            end
            else
            begin
                sum_first_reg <= acc_reg;
            end
        end
        if (cmd.load_result)
        begin
            result_reg.sum_a            <= sum_first_reg[asc_pkg::SUM_BITS-1:0];
            result_reg.sum_b            <= sum_second_reg[asc_pkg::SUM_BITS-1:0];
            result_reg.a_is_abundant    <= (ACC_W'(a_reg) < sum_first_reg);
            result_reg.pair_is_amicable <= (sum_first_reg == ACC_W'(b_reg)) &&
                                           (sum_second_reg == ACC_W'(a_reg));
        end
    end

    assign result = result_reg;

endmodule

FILE: src/asc_ctrl.sv
module asc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  asc_pkg::status_t status,
    output asc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_TEST,
        S_DIV,
        S_ACC,
        S_STORE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;
    logic   valid_reg;
    logic   valid_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        valid_next  = valid_reg;
        cmd         = '0;
        cmd.sel_second = second_reg;

        // drop the result once it is taken
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    second_next   = 1'b0;
                    state_next    = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_num = 1'b1;
                state_next   = S_TEST;
            end
            S_TEST:
            begin
                if (status.sq_gt_n)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = S_TEST;
            end
            S_STORE:
            begin
                cmd.store_sum = 1'b1;
                if (second_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    second_next = 1'b1;
                    state_next  = S_INIT;
                end
            end
            S_FINISH:
            begin
                // wait until the output register is free
                if (!valid_reg || result_ready)
                begin
                    cmd.load_result = 1'b1;
                    valid_next      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, number select and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            valid_reg  <= valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = valid_reg;

endmodule

FILE: src/asc_checker.sv
`include "assert_macros.svh"

module asc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input asc_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_ready,
    input asc_pkg::out_item_t result
);

    // A stalled result holds
    `ASC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // One item at a time: busy right after taking an item
    `ASC_ASSERT_NEXT(a_busy_after_item, clk, rst_n, item_valid && item_ready, !item_ready)

    // A new result appears only at the end of a search
    `ASC_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(result_valid), $past(!item_ready))

    // A zero sum never makes a abundant
    `ASC_ASSERT_SAME(a_zero_not_abundant, clk, rst_n, result_valid && (result.sum_a == '0), !result.a_is_abundant)

endmodule

bind aliquot_sum_classifier asc_checker u_asc_checker (.*);

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = asc_pkg::VALUE_BITS_DEFAULT;
    localparam int SUM_BITS = asc_pkg::SUM_BITS;
    localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_BITS) - 1;
    localparam longint unsigned SUM_MASK = (64'd1 << SUM_BITS) - 1;
    localparam int RANDOM_ITEMS = 77;
    localparam int PAUSE_AT = 50;
    localparam int STEADY_FIRST = 20;
    localparam int STEADY_LAST = 34;

    // Amicable pairs and perfect numbers below 2**16, as {a, b}
    localparam logic [11:0][31:0] FRIEND_PAIRS = {
        {16'd220, 16'd284}, {16'd1184, 16'd1210}, {16'd2620, 16'd2924},
        {16'd5020, 16'd5564}, {16'd6232, 16'd6368}, {16'd10744, 16'd10856},
        {16'd12285, 16'd14595}, {16'd17296, 16'd18416}, {16'd6, 16'd6},
        {16'd28, 16'd28}, {16'd496, 16'd496}, {16'd8128, 16'd8128}
    };

    typedef struct {
        asc_pkg::in_item_t  stim;
        bit                 known;
        asc_pkg::out_item_t want;
    } probe_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    asc_pkg::in_item_t   item;
    logic                result_valid;
    logic                result_ready;
    asc_pkg::out_item_t  result;

    // Typed expectation that travels with the item on the wire
    bit                  item_known;
    asc_pkg::out_item_t  item_want;

    asc_pkg::out_item_t  pending_sums[$];
    int                  errors;
    bit                  no_gaps;

    aliquot_sum_classifier #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run well past the slowest legal schedule
    initial
    begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Sum of the divisors of n below n itself
    function automatic longint unsigned proper_divisor_sum(longint unsigned n);
        longint unsigned total;
        longint unsigned d;
        total = 0;
        if (n < 2)
            return 0;
        for (d = 1; d * d <= n; d++)
        begin
            if (n % d == 0)
            begin
                total += d;
                if (n / d != d)
                    total += n / d;
            end
        end
        return total - n;
    endfunction

    function automatic asc_pkg::out_item_t classify_pair(asc_pkg::in_item_t it);
        longint unsigned a;
        longint unsigned b;
        longint unsigned sa;
        longint unsigned sb;
        asc_pkg::out_item_t r;
        a = it.value_a & VALUE_MASK;
        b = it.value_b & VALUE_MASK;
        sa = proper_divisor_sum(a);
        sb = proper_divisor_sum(b);
        r.sum_a = SUM_BITS'(sa & SUM_MASK);
        r.sum_b = SUM_BITS'(sb & SUM_MASK);
        r.a_is_abundant = (a < sa);
        r.pair_is_amicable = (sa == b) && (sb == a);
        return r;
    endfunction

    function automatic probe_t row(logic [15:0] a, logic [15:0] b);
        probe_t p;
        p.stim.value_a = a;
        p.stim.value_b = b;
        p.known = 1'b0;
        p.want = '0;
        return p;
    endfunction

    function automatic probe_t row_known(logic [15:0] a, logic [15:0] b,
                                         int sa, int sb, bit abundant, bit amicable);
        probe_t p;
        p = row(a, b);
        p.known = 1'b1;
        p.want.sum_a = SUM_BITS'(sa);
        p.want.sum_b = SUM_BITS'(sb);
        p.want.a_is_abundant = abundant;
        p.want.pair_is_amicable = amicable;
        return p;
    endfunction

    // Value of random bit length, so most searches stay short
    function automatic logic [15:0] sized_value();
        int nbits;
        logic [15:0] v;
        nbits = $urandom_range(0, 16);
        v = 16'($urandom);
        if (nbits == 0)
            return '0;
        return v >> (16 - nbits);
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Offer one item, then hold it until accepted
    task automatic send_item(probe_t p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= p.stim;
        item_known <= p.known;
        item_want <= p.want;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Record expectations on accepted items, compare accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                pending_sums.push_back(item_known ? item_want : classify_pair(item));
            if (result_valid && result_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    asc_pkg::out_item_t want;
                    want = pending_sums.pop_front();
                    check_field("sum_a", want.sum_a, result.sum_a);
                    check_field("sum_b", want.sum_b, result.sum_b);
                    check_field("a_is_abundant", want.a_is_abundant, result.a_is_abundant);
                    check_field("pair_is_amicable", want.pair_is_amicable,
                                result.pair_is_amicable);
                end
            end
        end
    end

    // Stall the result side by a random count per item
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // Reset, directed table, random items, drain
    initial
    begin
        probe_t probes[$];
        probe_t p;
        longint unsigned s;
        int kind;
        int pick;

        errors = 0;
        no_gaps = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        item_known <= 1'b0;
        item_want <= '0;

        // Zero and one, primes, perfect numbers, amicable pairs, extremes
        probes.push_back(row_known(16'd0, 16'd0, 0, 0, 1'b0, 1'b1));
        probes.push_back(row_known(16'd1, 16'd1, 0, 0, 1'b0, 1'b0));
        probes.push_back(row_known(16'd0, 16'd1, 0, 0, 1'b0, 1'b0));
        probes.push_back(row_known(16'd1, 16'd0, 0, 0, 1'b0, 1'b0));
        probes.push_back(row_known(16'd2, 16'd3, 1, 1, 1'b0, 1'b0));
        probes.push_back(row_known(16'd6, 16'd6, 6, 6, 1'b0, 1'b1));
        probes.push_back(row_known(16'd28, 16'd28, 28, 28, 1'b0, 1'b1));
        probes.push_back(row_known(16'd496, 16'd496, 496, 496, 1'b0, 1'b1));
        probes.push_back(row_known(16'd8128, 16'd8128, 8128, 8128, 1'b0, 1'b1));
        probes.push_back(row_known(16'd220, 16'd284, 284, 220, 1'b1, 1'b1));
        probes.push_back(row_known(16'd284, 16'd220, 220, 284, 1'b0, 1'b1));
        probes.push_back(row_known(16'd12, 16'd16, 16, 15, 1'b1, 1'b0));
        probes.push_back(row_known(16'd12285, 16'd14595, 14595, 12285, 1'b1, 1'b1));
        probes.push_back(row_known(16'd65521, 16'd65521, 1, 1, 1'b0, 1'b0));
        probes.push_back(row(16'hFFFF, 16'hFFFF));
        probes.push_back(row(16'hFFFF, 16'h0000));
        probes.push_back(row(16'h0000, 16'hFFFF));
        probes.push_back(row(16'hAAAA, 16'h5555));
        probes.push_back(row(16'h5555, 16'hAAAA));
        probes.push_back(row(16'h8000, 16'h7FFF));
        probes.push_back(row(16'd55440, 16'd45360));
        probes.push_back(row(16'd17296, 16'd18416));
        probes.push_back(row(16'd6, 16'd28));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
            send_item(probes[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= STEADY_FIRST) && (n <= STEADY_LAST);

            // Hold off until every result is back
            if (n == PAUSE_AT)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending_sums.size() != 0)
                    @(posedge clk);
            end

            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                pick = $urandom_range(0, 11);
                if ($urandom_range(0, 1) == 0)
                    p = row(FRIEND_PAIRS[pick][31:16], FRIEND_PAIRS[pick][15:0]);
                else
                    p = row(FRIEND_PAIRS[pick][15:0], FRIEND_PAIRS[pick][31:16]);
            end
            else if (kind <= 4)
            begin
                // Partner equal to the sum of a where that fits in 16 bits: first half of the pairing test then holds
                p = row(sized_value(), 16'd0);
                s = proper_divisor_sum(p.stim.value_a);
                p.stim.value_b = (s <= 64'hFFFF) ? 16'(s) : sized_value();
            end
            else if (kind == 5)
            begin
                p = row(sized_value(), 16'd0);
                p.stim.value_b = p.stim.value_a;
            end
            else
                p = row(sized_value(), sized_value());
            send_item(p);
        end
        no_gaps = 1'b0;

        // Drain, then allow one more search time for stray results
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (10000) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: aliquot_sum_classifier.f
+incdir+src
src/asc_pkg.sv
src/asc_div.sv
src/asc_datapath.sv
src/asc_ctrl.sv
src/aliquot_sum_classifier.sv
src/asc_checker.sv
tb/testbench.sv
